/* sv/owtr_pkg.sv */
// Shared types and constants for the single-wire temperature reader.
`default_nettype none
package owtr_pkg;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_RST_LOW   = 10'b00_0000_0010,
    PH_RST_REL   = 10'b00_0000_0100,
    PH_PRES_LOW  = 10'b00_0000_1000,
    PH_PRES_HIGH = 10'b00_0001_0000,
    PH_WR_LOW    = 10'b00_0010_0000,
    PH_WR_HIGH   = 10'b00_0100_0000,
    PH_RD_LOW    = 10'b00_1000_0000,
    PH_RD_WAIT   = 10'b01_0000_0000,
    PH_RD_REC    = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [2:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_RESET_RELEASE = 3'd1,
    CFG_PRES_TIMEOUT  = 3'd2,
    CFG_SLOT_TIME     = 3'd3,
    CFG_SHORT_PULSE   = 3'd4,
    CFG_SAMPLE_DELAY  = 3'd5,
    CFG_READ_RECOVERY = 3'd6
  } cfg_idx_t;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 10;
  localparam int TICK_W = 10;
  localparam int STEP_W = 4;
  localparam int TEMP_W = 17;

  localparam logic [STEP_W-1:0] STEP_RESET1  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SKIP1   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CONVERT = 4'd2;
  localparam logic [STEP_W-1:0] STEP_RESET2  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SKIP2   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_RDSCR   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RDLO    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RDHI    = 4'd7;

  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT      = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;
  localparam logic [4:0] NEG_TOP_BITS     = 5'h1F;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [7:0] reset_release_time;
    logic [9:0] presence_timeout;
    logic [7:0] slot_time;
    logic [3:0] short_pulse;
    logic [3:0] read_sample_delay;
    logic [7:0] read_recovery;
  } owtr_cfg_t;

  typedef struct packed {
    logic              [TEMP_W-1:0] temperature;
    logic                           presence_fail;
    logic                           result_valid;
    logic                           busy_res;
    logic                           bus_pull_low;
  } owtr_res_t;

endpackage
`default_nettype wire

/* sv/owtr_cfg.sv */
// Timing register bank written through the plain configuration port.
`default_nettype none
module owtr_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [owtr_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [owtr_pkg::CFG_DW-1:0] cfg_wdata,
  output owtr_pkg::owtr_cfg_t             cfg
);
  import owtr_pkg::*;

  owtr_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time     <= 10'd750;
      cfg_r.reset_release_time <= 8'd20;
      cfg_r.presence_timeout   <= 10'd200;
      cfg_r.slot_time          <= 8'd60;
      cfg_r.short_pulse        <= 4'd2;
      cfg_r.read_sample_delay  <= 4'd2;
      cfg_r.read_recovery      <= 8'd50;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_RESET_LOW:     cfg_r.reset_low_time     <= cfg_wdata;
        CFG_RESET_RELEASE: cfg_r.reset_release_time <= cfg_wdata[7:0];
        CFG_PRES_TIMEOUT:  cfg_r.presence_timeout   <= cfg_wdata;
        CFG_SLOT_TIME:     cfg_r.slot_time          <= cfg_wdata[7:0];
        CFG_SHORT_PULSE:   cfg_r.short_pulse        <= cfg_wdata[3:0];
        CFG_SAMPLE_DELAY:  cfg_r.read_sample_delay  <= cfg_wdata[3:0];
        CFG_READ_RECOVERY: cfg_r.read_recovery      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* sv/owtr_core.sv */
// Bus sequencer: phase state machine stepped once per accepted beat.
`default_nettype none
module owtr_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                req_type,
  input  wire logic                bus_level,
  input  wire owtr_pkg::owtr_cfg_t cfg,
  output owtr_pkg::owtr_res_t      res
);
  import owtr_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [STEP_W-1:0] step_index_r, step_index_nxt;
  logic [TICK_W-1:0] tick_count_r, tick_count_nxt;
  logic [2:0]        bit_index_r, bit_index_nxt;
  logic [7:0]        shift_byte_r, shift_byte_nxt;
  logic [7:0]        low_byte_r, low_byte_nxt;
  logic              presence_error_r, presence_error_nxt;

  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] dur;
  logic              expired;
  logic              cur_bit;
  logic              go;
  logic [STEP_W-1:0] go_step;
  logic [15:0]       word;
  logic              valid;
  logic [TEMP_W-1:0] temp;

  assign cur_bit  = shift_byte_r[0];
  assign tick_inc = tick_count_r + 10'd1;
  assign word     = {shift_byte_r, low_byte_r};

  always_comb begin
    dur = cfg.presence_timeout;
    unique case (phase_r)
      PH_RST_LOW:  dur = cfg.reset_low_time;
      PH_RST_REL:  dur = {2'b00, cfg.reset_release_time};
      PH_WR_LOW:   dur = cur_bit ? {6'd0, cfg.short_pulse} : {2'b00, cfg.slot_time};
      PH_WR_HIGH:  dur = cur_bit ? {2'b00, cfg.slot_time} : {6'd0, cfg.short_pulse};
      PH_RD_LOW:   dur = {6'd0, cfg.short_pulse};
      PH_RD_WAIT:  dur = {6'd0, cfg.read_sample_delay};
      PH_RD_REC:   dur = {2'b00, cfg.read_recovery};
      default:     dur = cfg.presence_timeout;
    endcase
  end

  assign expired = (tick_inc >= dur);

  always_comb begin
    phase_nxt          = phase_r;
    step_index_nxt     = step_index_r;
    tick_count_nxt     = tick_count_r;
    bit_index_nxt      = bit_index_r;
    shift_byte_nxt     = shift_byte_r;
    low_byte_nxt       = low_byte_r;
    presence_error_nxt = presence_error_r;
    go                 = 1'b0;
    go_step            = step_index_r + 4'd1;
    valid              = 1'b0;
    temp               = '0;

    if (req_type) begin
      if (phase_r == PH_IDLE) begin
        presence_error_nxt = 1'b0;
        go                 = 1'b1;
        go_step            = STEP_RESET1;
      end
    end else begin
      tick_count_nxt = expired ? '0 : tick_inc;
      unique case (phase_r)
        PH_IDLE: tick_count_nxt = tick_count_r;
        PH_RST_LOW: if (expired) phase_nxt = PH_RST_REL;
        PH_RST_REL: if (expired) phase_nxt = PH_PRES_LOW;
        PH_PRES_LOW: begin
          if (!bus_level) begin
            tick_count_nxt = '0;
            phase_nxt      = PH_PRES_HIGH;
          end else if (expired) begin
            presence_error_nxt = 1'b1;
            go                 = 1'b1;
          end
        end
        PH_PRES_HIGH: begin
          if (bus_level) begin
            tick_count_nxt = tick_count_r;
            go             = 1'b1;
          end else if (expired) begin
            presence_error_nxt = 1'b1;
            go                 = 1'b1;
          end
        end
        PH_WR_LOW: if (expired) phase_nxt = PH_WR_HIGH;
        PH_WR_HIGH: begin
          if (expired) begin
            shift_byte_nxt = {1'b0, shift_byte_r[7:1]};
            if (bit_index_r == 3'd7) begin
              go = 1'b1;
            end else begin
              bit_index_nxt = bit_index_r + 3'd1;
              phase_nxt     = PH_WR_LOW;
            end
          end
        end
        PH_RD_LOW: if (expired) phase_nxt = PH_RD_WAIT;
        PH_RD_WAIT: begin
          if (expired) begin
            shift_byte_nxt = {bus_level, shift_byte_r[7:1]};
            phase_nxt      = PH_RD_REC;
          end
        end
        PH_RD_REC: begin
          if (expired) begin
            if (bit_index_r != 3'd7) begin
              bit_index_nxt = bit_index_r + 3'd1;
              phase_nxt     = PH_RD_LOW;
            end else if (step_index_r == STEP_RDLO) begin
              low_byte_nxt = shift_byte_r;
              go           = 1'b1;
            end else begin
              valid          = 1'b1;
              temp           = {(word[15:11] == NEG_TOP_BITS), word};
              phase_nxt      = PH_IDLE;
              step_index_nxt = STEP_RESET1;
              bit_index_nxt  = '0;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (go) begin
      step_index_nxt = go_step;
      tick_count_nxt = '0;
      bit_index_nxt  = '0;
      case (go_step)
        STEP_RESET1, STEP_RESET2: phase_nxt = PH_RST_LOW;
        STEP_SKIP1, STEP_SKIP2: begin
          shift_byte_nxt = CMD_SKIP_ROM;
          phase_nxt      = PH_WR_LOW;
        end
        STEP_CONVERT: begin
          shift_byte_nxt = CMD_CONVERT;
          phase_nxt      = PH_WR_LOW;
        end
        STEP_RDSCR: begin
          shift_byte_nxt = CMD_READ_SCRATCH;
          phase_nxt      = PH_WR_LOW;
        end
        STEP_RDLO, STEP_RDHI: begin
          shift_byte_nxt = '0;
          phase_nxt      = PH_RD_LOW;
        end
        default: begin
          phase_nxt      = PH_IDLE;
          step_index_nxt = STEP_RESET1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      step_index_r     <= '0;
      tick_count_r     <= '0;
      bit_index_r      <= '0;
      shift_byte_r     <= '0;
      low_byte_r       <= '0;
      presence_error_r <= 1'b0;
    end else if (accept) begin
      phase_r          <= phase_nxt;
      step_index_r     <= step_index_nxt;
      tick_count_r     <= tick_count_nxt;
      bit_index_r      <= bit_index_nxt;
      shift_byte_r     <= shift_byte_nxt;
      low_byte_r       <= low_byte_nxt;
      presence_error_r <= presence_error_nxt;
    end
  end

  assign res.bus_pull_low  = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_WR_LOW) ||
                             (phase_nxt == PH_RD_LOW);
  assign res.busy_res      = (phase_nxt != PH_IDLE);
  assign res.result_valid  = valid;
  assign res.presence_fail = presence_error_nxt;
  assign res.temperature   = temp;

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_count_r == '0 && bit_index_r == '0 && step_index_r == '0))
    else $error("idle with stale counters");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req_type && phase_r == PH_IDLE) |=> (phase_r == PH_RST_LOW && !presence_error_r))
    else $error("start did not open a reset pulse");

  a_fail_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(presence_error_r) |->
      ($past(phase_r) == PH_PRES_LOW || $past(phase_r) == PH_PRES_HIGH))
    else $error("presence flag set outside a presence check");

endmodule
`default_nettype wire

/* sv/onewire_temperature_reader.sv */
// Top level: stream ports, timing registers, sequencer and output register.
// One input beat per clock while in_tready is high. Each beat (a 1 us tick or a
// start request) steps the sequencer state in the cycle it is accepted, and its
// result beat appears on the output register on the next clock. in_tready is high
// whenever the output register is empty or its beat is taken in the same cycle, so
// a steady stream with out_tready held high runs at one beat per cycle.
`default_nettype none
module onewire_temperature_reader (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  input  wire logic [7:0]                  in_tdata,  // [0] bus_level, [7:1] zero
  input  wire logic                        in_tuser,  // [0] req_type
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  // [0] bus_pull_low, [1] busy_res, [2] result_valid, [3] presence_fail,
  // [20:4] temperature, [23:21] zero
  output      logic [23:0]                 out_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [owtr_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [owtr_pkg::CFG_DW-1:0] cfg_wdata
);
  import owtr_pkg::*;

  owtr_cfg_t cfg;
  owtr_res_t res;
  owtr_res_t out_data_r;
  logic      out_valid_r;
  logic      accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  owtr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  owtr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_tuser),
    .bus_level (in_tdata[0]),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

endmodule
`default_nettype wire

/* tb/sv/onewire_temperature_reader_tb.sv */
// Self-checking testbench for the single-wire temperature reader: random ticks, starts and timings.
`timescale 1ns / 1ps
module onewire_temperature_reader_tb;
  import owtr_pkg::*;

  localparam int IDLE_PCT    = 32;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    phase_t            ph;
    logic [STEP_W-1:0] step;
    logic [TICK_W-1:0] ticks;
    logic [2:0]        bitn;
    logic [7:0]        shreg;
    logic [7:0]        lo;
    logic              perr;
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic bus;
  } bus_event_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;  // [0] bus_level, [7:1] zero
  logic                in_tuser = 1'b0; // [0] req_type
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [23:0]         out_tdata;  // [0] pull_low, [1] busy, [2] valid, [3] pres_fail, [20:4] temp
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  owtr_cfg_t    tim_cfg;
  seq_state_t   model_st;
  seq_state_t   gen_st;
  owtr_res_t    gen_res;
  bus_event_t   bus_event_q[$];
  owtr_res_t    due_status_q[$];
  int           events_queued = 0;
  int           events_taken = 0;
  int           status_mismatches = 0;
  int           cycle_cnt = 0;
  logic         beat_taken = 1'b0;
  logic         steady = 1'b0;

  onewire_temperature_reader i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- bus master prediction ----------------
  task automatic enter_step(inout seq_state_t s);
    s.ticks = '0;
    s.bitn  = '0;
    case (s.step)
      STEP_RESET1, STEP_RESET2: s.ph = PH_RST_LOW;
      STEP_SKIP1, STEP_SKIP2: begin
        s.shreg = CMD_SKIP_ROM;
        s.ph    = PH_WR_LOW;
      end
      STEP_CONVERT: begin
        s.shreg = CMD_CONVERT;
        s.ph    = PH_WR_LOW;
      end
      STEP_RDSCR: begin
        s.shreg = CMD_READ_SCRATCH;
        s.ph    = PH_WR_LOW;
      end
      STEP_RDLO, STEP_RDHI: begin
        s.shreg = '0;
        s.ph    = PH_RD_LOW;
      end
      default: begin
        s.ph   = PH_IDLE;
        s.step = '0;
      end
    endcase
  endtask

  task automatic next_step(inout seq_state_t s);
    s.step = s.step + 1'b1;
    enter_step(s);
  endtask

  // zero duration behaves as one tick through the >= compare
  task automatic count_tick(inout seq_state_t s, input logic [TICK_W-1:0] dur,
                            output logic done);
    s.ticks = s.ticks + 1'b1;
    done = (s.ticks >= dur);
    if (done) s.ticks = '0;
  endtask

  task automatic bus_master_step(inout seq_state_t s, input logic start, input logic bus,
                                 output owtr_res_t r);
    logic        done;
    logic        wbit;
    logic [15:0] word;
    wbit = s.shreg[0];
    r = '0;
    if (start) begin
      if (s.ph == PH_IDLE) begin
        s.perr = 1'b0;
        s.step = STEP_RESET1;
        enter_step(s);
      end
    end else begin
      case (s.ph)
        PH_RST_LOW: begin
          count_tick(s, tim_cfg.reset_low_time, done);
          if (done) s.ph = PH_RST_REL;
        end
        PH_RST_REL: begin
          count_tick(s, tim_cfg.reset_release_time, done);
          if (done) s.ph = PH_PRES_LOW;
        end
        PH_PRES_LOW: begin
          if (!bus) begin
            s.ticks = '0;
            s.ph    = PH_PRES_HIGH;
          end else begin
            count_tick(s, tim_cfg.presence_timeout, done);
            if (done) begin
              s.perr = 1'b1;
              next_step(s);
            end
          end
        end
        PH_PRES_HIGH: begin
          if (bus) begin
            next_step(s);
          end else begin
            count_tick(s, tim_cfg.presence_timeout, done);
            if (done) begin
              s.perr = 1'b1;
              next_step(s);
            end
          end
        end
        PH_WR_LOW: begin
          count_tick(s, wbit ? tim_cfg.short_pulse : tim_cfg.slot_time, done);
          if (done) s.ph = PH_WR_HIGH;
        end
        PH_WR_HIGH: begin
          count_tick(s, wbit ? tim_cfg.slot_time : tim_cfg.short_pulse, done);
          if (done) begin
            s.shreg = s.shreg >> 1;
            if (s.bitn == 3'd7) begin
              next_step(s);
            end else begin
              s.bitn = s.bitn + 1'b1;
              s.ph   = PH_WR_LOW;
            end
          end
        end
        PH_RD_LOW: begin
          count_tick(s, tim_cfg.short_pulse, done);
          if (done) s.ph = PH_RD_WAIT;
        end
        PH_RD_WAIT: begin
          count_tick(s, tim_cfg.read_sample_delay, done);
          if (done) begin
            s.shreg = {bus, s.shreg[7:1]};
            s.ph    = PH_RD_REC;
          end
        end
        PH_RD_REC: begin
          count_tick(s, tim_cfg.read_recovery, done);
          if (done) begin
            if (s.bitn != 3'd7) begin
              s.bitn = s.bitn + 1'b1;
              s.ph   = PH_RD_LOW;
            end else if (s.step == STEP_RDLO) begin
              s.lo = s.shreg;
              next_step(s);
            end else begin
              word = {s.shreg, s.lo};
              r.temperature  = {(word[15:11] == NEG_TOP_BITS), word};
              r.result_valid = 1'b1;
              s.ph    = PH_IDLE;
              s.step  = '0;
              s.ticks = '0;
              s.bitn  = '0;
            end
          end
        end
        default: s.ph = PH_IDLE;
      endcase
    end
    r.bus_pull_low  = (s.ph == PH_RST_LOW) || (s.ph == PH_WR_LOW) || (s.ph == PH_RD_LOW);
    r.busy_res      = (s.ph != PH_IDLE);
    r.presence_fail = s.perr;
  endtask

  // ---------------- driver and monitors ----------------
  always @(negedge clk) begin : drive_in
    bus_event_t ev;
    if (in_tvalid && !beat_taken) begin
      // hold the beat until taken
    end else if (rst_n && bus_event_q.size() != 0 &&
                 (steady || $urandom_range(99) >= IDLE_PCT)) begin
      ev = bus_event_q.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= ev.start;
      in_tdata  <= {7'b0, ev.bus};
    end else begin
      in_tvalid <= 1'b0;
    end
    beat_taken = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : take_in
    owtr_res_t r;
    if (rst_n && in_tvalid && in_tready) begin
      bus_master_step(model_st, in_tuser, in_tdata[0], r);
      due_status_q.push_back(r);
      events_taken++;
      beat_taken = 1'b1;
    end
  end

  task automatic report_mismatch(input string msg);
    status_mismatches++;
    if (status_mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_out
    owtr_res_t got;
    owtr_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[20:0];
      if (due_status_q.size() == 0) begin
        report_mismatch($sformatf("unexpected status beat %h", out_tdata));
      end else begin
        want = due_status_q.pop_front();
        if (got.bus_pull_low !== want.bus_pull_low || got.busy_res !== want.busy_res ||
            got.result_valid !== want.result_valid ||
            got.presence_fail !== want.presence_fail ||
            got.temperature !== want.temperature || out_tdata[23:21] !== 3'b0)
          report_mismatch($sformatf(
            "exp pull=%b busy=%b valid=%b pfail=%b temp=%0d, got %b %b %b %b %0d pad=%b",
            want.bus_pull_low, want.busy_res, want.result_valid, want.presence_fail,
            $signed(want.temperature), got.bus_pull_low, got.busy_res, got.result_valid,
            got.presence_fail, $signed(got.temperature), out_tdata[23:21]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic queue_event(input logic start, input logic bus);
    bus_event_t ev;
    ev.start = start;
    ev.bus   = bus;
    bus_master_step(gen_st, start, bus, gen_res);
    bus_event_q.push_back(ev);
    events_queued++;
  endtask

  function automatic logic pick_level(input int mode);
    case (mode)
      1:       return $urandom_range(7) != 0;
      2:       return $urandom_range(7) == 0;
      default: return 1'($urandom_range(1));
    endcase
  endfunction

  task automatic queue_ticks(input int n);
    repeat (n) queue_event(1'b0, pick_level(0));
  endtask

  task automatic finish_read(input int mode);
    gen_res.result_valid = 1'b0;
    while (!gen_res.result_valid) begin
      if ($urandom_range(99) < 2) queue_event(1'b1, 1'($urandom_range(1)));
      else queue_event(1'b0, pick_level(mode));
    end
  endtask

  task automatic run_reads(input int n);
    repeat (n) begin
      repeat ($urandom_range(3)) queue_event(1'b0, 1'($urandom_range(1)));
      queue_event(1'b1, 1'($urandom_range(1)));
      finish_read($urandom_range(2));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (events_taken != events_queued || due_status_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RESET_LOW:     tim_cfg.reset_low_time     = val;
      CFG_RESET_RELEASE: tim_cfg.reset_release_time = val[7:0];
      CFG_PRES_TIMEOUT:  tim_cfg.presence_timeout   = val;
      CFG_SLOT_TIME:     tim_cfg.slot_time          = val[7:0];
      CFG_SHORT_PULSE:   tim_cfg.short_pulse        = val[3:0];
      CFG_SAMPLE_DELAY:  tim_cfg.read_sample_delay  = val[3:0];
      CFG_READ_RECOVERY: tim_cfg.read_recovery      = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input int rl, input int rr, input int pt, input int st,
                            input int sp, input int sd, input int rc);
    write_reg(CFG_RESET_LOW, CFG_DW'(rl));
    write_reg(CFG_RESET_RELEASE, CFG_DW'(rr));
    write_reg(CFG_PRES_TIMEOUT, CFG_DW'(pt));
    write_reg(CFG_SLOT_TIME, CFG_DW'(st));
    write_reg(CFG_SHORT_PULSE, CFG_DW'(sp));
    write_reg(CFG_SAMPLE_DELAY, CFG_DW'(sd));
    write_reg(CFG_READ_RECOVERY, CFG_DW'(rc));
  endtask

  initial begin
    tim_cfg.reset_low_time     = 10'd750;
    tim_cfg.reset_release_time = 8'd20;
    tim_cfg.presence_timeout   = 10'd200;
    tim_cfg.slot_time          = 8'd60;
    tim_cfg.short_pulse        = 4'd2;
    tim_cfg.read_sample_delay  = 4'd2;
    tim_cfg.read_recovery      = 8'd50;
    model_st    = '0;
    model_st.ph = PH_IDLE;
    gen_st      = model_st;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // idle ticks, start, start while busy, then part of a reset pulse at reset timings
    queue_event(1'b0, 1'b0);
    queue_event(1'b0, 1'b1);
    queue_event(1'b1, 1'b1);
    queue_event(1'b1, 1'b0);
    queue_event(1'b0, 1'b0);
    queue_event(1'b0, 1'b1);
    queue_ticks(100);

    // first read finishes the sequence left running above
    set_timing(0, 0, 0, 0, 0, 0, 0);
    run_reads(2);

    steady = 1'b1;
    set_timing(1, 1, 1, 1, 1, 1, 1);
    run_reads(2);
    wait_drained();
    steady = 1'b0;

    repeat (2) begin
      set_timing($urandom_range(6), $urandom_range(4), $urandom_range(6), $urandom_range(4),
                 $urandom_range(3), $urandom_range(3), $urandom_range(4));
      run_reads(1);
    end

    set_timing(1023, 255, 1023, 255, 15, 15, 255);
    queue_event(1'b1, 1'b0);
    queue_ticks(120);

    wait_drained();
    repeat (4) @(posedge clk);
    if (status_mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
